>>> rtl/msl_pkg.sv
// Shared types, codes and constants of the SysEx sample loader.
package msl_pkg;

    localparam int SIZE_BYTES = 3;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 7;
    localparam int LEN_W    = 21;
    localparam int PROG_W   = 4;
    localparam int CNT_W    = 2;
    localparam int CIDX_W   = 3;

    localparam logic [BYTE_W-1:0] BYTE_END = 8'hF7;

    localparam logic [CIDX_W-1:0] CFG_MANUF     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_DEVICE    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_CMD_LOAD  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_CMD_PATCH = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PATCH_LO  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_PATCH_HI  = 3'd5;

    typedef enum logic [3:0] {
        PH_MANUF  = 4'd0,
        PH_DEVICE = 4'd1,
        PH_CMD    = 4'd2,
        PH_SLOT   = 4'd3,
        PH_KIND   = 4'd4,
        PH_SIZE   = 4'd5,
        PH_XFER   = 4'd6,
        PH_PATCH  = 4'd7,
        PH_IGNORE = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        EV_HEADER   = 3'd0,
        EV_START    = 3'd1,
        EV_DATA     = 3'd2,
        EV_PATCH    = 3'd3,
        EV_DONE     = 3'd4,
        EV_MISMATCH = 3'd5,
        EV_REJECT   = 3'd6,
        EV_IGNORED  = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic   load_byte;
        logic   take_mfr;
        logic   take_slot;
        logic   take_kind;
        logic   take_size;
        logic   start_xfer;
        logic   count_data;
        logic   clear_hdr;
        logic   div_step;
        logic   res_load;
        logic   res_start;
        logic   res_data;
        logic   res_patch;
        t_event ev;
        logic   push;
    } t_dp_cmd;

    typedef struct packed {
        logic end_byte;
        logic bit7;
        logic hdr_match;
        logic is_load;
        logic is_patch;
        logic patch_ok;
        logic last_size;
        logic room;
        logic length_ok;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/msl_ctrl.sv
// Controller: message phase tracking and per-beat sequencing.
module msl_ctrl import msl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic              w_data_ok;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_data_ok  = (r_phase == PH_XFER) && !i_stat.end_byte && !i_stat.bit7 && i_stat.room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_MANUF;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_div_cnt = r_div_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_div_cnt = '0;
                n_state   = w_data_ok ? ST_DIV : ST_PUSH;
                if (i_stat.end_byte) begin
                    n_phase = PH_MANUF;
                end else begin
                    unique case (r_phase)
                        PH_MANUF:  n_phase = PH_DEVICE;
                        PH_DEVICE: n_phase = i_stat.hdr_match ? PH_CMD : PH_IGNORE;
                        PH_CMD: begin
                            if (i_stat.is_load) begin
                                n_phase = PH_SLOT;
                            end else if (i_stat.is_patch) begin
                                n_phase = PH_PATCH;
                            end else begin
                                n_phase = PH_IGNORE;
                            end
                        end
                        PH_SLOT:   n_phase = PH_KIND;
                        PH_KIND:   n_phase = PH_SIZE;
                        PH_SIZE:   n_phase = i_stat.last_size ? PH_XFER : PH_SIZE;
                        PH_XFER:   n_phase = PH_XFER;
                        PH_PATCH:  n_phase = PH_IGNORE;
                        default:   n_phase = r_phase;
                    endcase
                end
            end
            ST_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == '1) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.ev        = EV_IGNORED;
        o_cmd.load_byte = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.push      = (r_state == ST_PUSH) && i_stat.out_free;
        if (r_state == ST_EXEC) begin
            o_cmd.res_load = 1'b1;
            if (i_stat.end_byte) begin
                o_cmd.clear_hdr = 1'b1;
                if (r_phase == PH_XFER) begin
                    o_cmd.ev = i_stat.length_ok ? EV_DONE : EV_MISMATCH;
                end else if (r_phase <= PH_SIZE) begin
                    o_cmd.ev = EV_REJECT;
                end else begin
                    o_cmd.ev = EV_IGNORED;
                end
            end else begin
                unique case (r_phase)
                    PH_MANUF: begin
                        o_cmd.take_mfr = 1'b1;
                        o_cmd.ev       = EV_HEADER;
                    end
                    PH_DEVICE: o_cmd.ev = i_stat.hdr_match ? EV_HEADER : EV_REJECT;
                    PH_CMD: begin
                        o_cmd.ev = (i_stat.is_load || i_stat.is_patch) ? EV_HEADER : EV_REJECT;
                    end
                    PH_SLOT: begin
                        o_cmd.take_slot = 1'b1;
                        o_cmd.ev        = EV_HEADER;
                    end
                    PH_KIND: begin
                        o_cmd.take_kind = 1'b1;
                        o_cmd.ev        = EV_HEADER;
                    end
                    PH_SIZE: begin
                        o_cmd.take_size = 1'b1;
                        if (i_stat.last_size) begin
                            o_cmd.start_xfer = 1'b1;
                            o_cmd.res_start  = 1'b1;
                            o_cmd.ev         = EV_START;
                        end else begin
                            o_cmd.ev = EV_HEADER;
                        end
                    end
                    PH_XFER: begin
                        if (w_data_ok) begin
                            o_cmd.count_data = 1'b1;
                            o_cmd.res_data   = 1'b1;
                            o_cmd.ev         = EV_DATA;
                        end else begin
                            o_cmd.ev = EV_IGNORED;
                        end
                    end
                    PH_PATCH: begin
                        if (i_stat.patch_ok) begin
                            o_cmd.res_patch = 1'b1;
                            o_cmd.ev        = EV_PATCH;
                        end else begin
                            o_cmd.ev = EV_REJECT;
                        end
                    end
                    default: o_cmd.ev = EV_IGNORED;
                endcase
            end
        end
    end

endmodule

>>> rtl/msl_dp.sv
// Datapath: settings, header fields, byte counter, progress divider, result registers.
module msl_dp import msl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [BYTE_W-1:0]   i_in_byte,
    input  logic                i_cfg_valid,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_out_ready,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_out_valid,
    output logic [2:0]          o_event_res,
    output logic [BYTE_W-1:0]   o_slot,
    output logic [BYTE_W-1:0]   o_sample_kind,
    output logic [LEN_W-1:0]    o_sample_length,
    output logic [CFG_W-1:0]    o_data_value,
    output logic [LEN_W-1:0]    o_data_offset,
    output logic [PROG_W-1:0]   o_progress,
    output logic [BYTE_W-1:0]   o_patch_number
);

    logic [CFG_W-1:0]  r_mfr_id, r_dev_id, r_cmd_load, r_cmd_patch, r_patch_lo, r_patch_hi;
    logic [BYTE_W-1:0] r_byte, r_seen, r_slot, r_kind;
    logic [LEN_W-1:0]  r_size, r_bytes;
    logic [CNT_W-1:0]  r_size_cnt;
    logic [LEN_W-1:0]  r_rem;
    logic [PROG_W-1:0] r_quo;
    logic              r_full;

    t_event            r_pend_ev;
    logic [BYTE_W-1:0] r_pend_slot, r_pend_kind, r_pend_patch;
    logic [LEN_W-1:0]  r_pend_len, r_pend_off;
    logic [CFG_W-1:0]  r_pend_val;
    logic              r_pend_prog;
    logic              r_out_valid;

    logic [LEN_W-1:0]  n_size;
    logic [LEN_W-1:0]  w_bytes_inc;
    logic [LEN_W:0]    w_shift;
    logic              w_ge;
    logic [CNT_W:0]    w_cnt_inc;

    always_comb begin
        unique case (r_size_cnt)
            2'd0:    n_size = r_size | {14'b0, r_byte[6:0]};
            2'd1:    n_size = r_size | {7'b0, r_byte[6:0], 7'b0};
            2'd2:    n_size = r_size | {r_byte[6:0], 14'b0};
            default: n_size = r_size;
        endcase
    end

    assign w_bytes_inc = r_bytes + 1'b1;
    assign w_shift     = {r_rem, 1'b0};
    assign w_ge        = (w_shift >= {1'b0, r_size});
    assign w_cnt_inc   = {1'b0, r_size_cnt} + 1'b1;

    assign o_stat.end_byte  = (r_byte == BYTE_END);
    assign o_stat.bit7      = r_byte[BYTE_W-1];
    assign o_stat.hdr_match = (r_seen == {1'b0, r_mfr_id}) && (r_byte == {1'b0, r_dev_id});
    assign o_stat.is_load   = (r_byte == {1'b0, r_cmd_load});
    assign o_stat.is_patch  = (r_byte == {1'b0, r_cmd_patch});
    assign o_stat.patch_ok  = (r_byte >= {1'b0, r_patch_lo}) && (r_byte <= {1'b0, r_patch_hi});
    assign o_stat.last_size = (w_cnt_inc >= (CNT_W+1)'(SIZE_BYTES));
    assign o_stat.room      = (r_bytes < r_size);
    assign o_stat.length_ok = (r_bytes == r_size);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mfr_id    <= 7'd125;
            r_dev_id    <= 7'd78;
            r_cmd_load  <= 7'd1;
            r_cmd_patch <= 7'd3;
            r_patch_lo  <= 7'd0;
            r_patch_hi  <= 7'd99;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MANUF:     r_mfr_id    <= i_cfg_data;
                CFG_DEVICE:    r_dev_id    <= i_cfg_data;
                CFG_CMD_LOAD:  r_cmd_load  <= i_cfg_data;
                CFG_CMD_PATCH: r_cmd_patch <= i_cfg_data;
                CFG_PATCH_LO:  r_patch_lo  <= i_cfg_data;
                CFG_PATCH_HI:  r_patch_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_hdr) begin
            r_seen     <= '0;
            r_slot     <= '0;
            r_kind     <= '0;
            r_size     <= '0;
            r_size_cnt <= '0;
            r_bytes    <= '0;
        end else begin
            if (i_cmd.take_mfr) begin
                r_seen <= r_byte;
            end
            if (i_cmd.take_slot) begin
                r_slot <= r_byte;
            end
            if (i_cmd.take_kind) begin
                r_kind     <= r_byte;
                r_size     <= '0;
                r_size_cnt <= '0;
            end
            if (i_cmd.take_size) begin
                r_size     <= n_size;
                r_size_cnt <= w_cnt_inc[CNT_W-1:0];
            end
            if (i_cmd.start_xfer) begin
                r_bytes <= '0;
            end
            if (i_cmd.count_data) begin
                r_bytes <= w_bytes_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_in_byte;
        end
        if (i_cmd.count_data) begin
            r_rem  <= w_bytes_inc;
            r_quo  <= '0;
            r_full <= (w_bytes_inc == r_size);
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? LEN_W'(w_shift - {1'b0, r_size}) : w_shift[LEN_W-1:0];
            r_quo <= {r_quo[PROG_W-2:0], w_ge};
        end
        if (i_cmd.res_load) begin
            r_pend_ev    <= i_cmd.ev;
            r_pend_slot  <= i_cmd.res_start ? r_slot : '0;
            r_pend_kind  <= i_cmd.res_start ? r_kind : '0;
            r_pend_len   <= i_cmd.res_start ? n_size : '0;
            r_pend_val   <= i_cmd.res_data ? r_byte[CFG_W-1:0] : '0;
            r_pend_off   <= i_cmd.res_data ? r_bytes : '0;
            r_pend_prog  <= i_cmd.res_data;
            r_pend_patch <= i_cmd.res_patch ? r_byte : '0;
        end
        if (i_cmd.push) begin
            o_event_res     <= r_pend_ev;
            o_slot          <= r_pend_slot;
            o_sample_kind   <= r_pend_kind;
            o_sample_length <= r_pend_len;
            o_data_value    <= r_pend_val;
            o_data_offset   <= r_pend_off;
            o_progress      <= !r_pend_prog ? '0 : (r_full ? '1 : r_quo);
            o_patch_number  <= r_pend_patch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/midi_sysex_sample_loader.sv
// Top level of the MIDI SysEx sample loader and patch selector.
// Feed the message bytes that follow the 0xF0 start byte; every byte yields exactly one
// result beat. A byte holds the input while it is accepted, executed and handed off, and
// its result is registered at the hand-off; a counted sample data byte also holds it while
// the progress divider runs, which retires one quotient bit per cycle. One result may wait
// in the output register while the next byte is taken and worked on; the hand-off then
// holds until that result is taken. Settings writes are taken in any cycle and belong
// between messages.
module midi_sysex_sample_loader import msl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [BYTE_W-1:0]   i_in_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_event_res,
    output logic [BYTE_W-1:0]   o_slot,
    output logic [BYTE_W-1:0]   o_sample_kind,
    output logic [LEN_W-1:0]    o_sample_length,
    output logic [CFG_W-1:0]    o_data_value,
    output logic [LEN_W-1:0]    o_data_offset,
    output logic [PROG_W-1:0]   o_progress,
    output logic [BYTE_W-1:0]   o_patch_number,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    msl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    msl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_event_res     (o_event_res),
        .o_slot          (o_slot),
        .o_sample_kind   (o_sample_kind),
        .o_sample_length (o_sample_length),
        .o_data_value    (o_data_value),
        .o_data_offset   (o_data_offset),
        .o_progress      (o_progress),
        .o_patch_number  (o_patch_number)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while a byte is in flight");

    a_data_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_DATA) |->
        (o_data_value == '0 && o_data_offset == '0 && o_progress == '0))
        else $error("data fields set on a non-data result");

    a_start_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_START) |->
        (o_slot == '0 && o_sample_kind == '0 && o_sample_length == '0))
        else $error("sample start fields set on another result");

    a_patch_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_PATCH) |-> (o_patch_number == '0))
        else $error("patch number set on another result");

endmodule
